### rtl/srrip_db_pkg.sv
package srrip_db_pkg;

    // Cache geometry
    localparam int unsigned NUM_SETS = 2048;
    localparam int unsigned NUM_WAYS = 16;

    // Field widths
    localparam int unsigned SET_W   = 11;
    localparam int unsigned WAY_W   = 4;
    localparam int unsigned CFG_W   = 5;
    localparam int unsigned TALLY_W = 20;

    // Derived widths
    localparam int unsigned ADDR_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int unsigned LANE_W = $clog2(NUM_WAYS);

    // Line state codes
    localparam logic [1:0] RRPV_DISTANT = 2'd3;
    localparam logic [1:0] RRPV_NEAR    = 2'd1;
    localparam logic [1:0] RRPV_HIT     = 2'd0;
    localparam logic [1:0] REUSE_INIT   = 2'd1;
    localparam logic [1:0] REUSE_MAX    = 2'd3;
    localparam logic [1:0] REUSE_NONE   = 2'd0;

    // Reset value of the decay interval register
    localparam logic [CFG_W-1:0] DECAY_LOG2_RST = 5'd12;

    // Action codes
    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef logic [NUM_WAYS-1:0][1:0] lanes_t;

    // One memory row holds a whole set
    typedef struct packed {
        lanes_t rrpv;
        lanes_t reuse;
    } row_t;

    // Request from the sequencer to the set store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        row_t              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_QDONE,
        ST_UPD,
        ST_DECAY,
        ST_DECAY_LAST
    } state_t;

    // Row value after reset
    function automatic row_t reset_row();
        row_t r;
        int   w;
        for (w = 0; w < NUM_WAYS; w++)
        begin
            r.rrpv[w]  = RRPV_DISTANT;
            r.reuse[w] = REUSE_INIT;
        end
        return r;
    endfunction

    // Every reuse counter of a row steps toward zero
    function automatic row_t decay_row(row_t x);
        row_t r;
        int   w;
        r = x;
        for (w = 0; w < NUM_WAYS; w++)
        begin
            if (x.reuse[w] != REUSE_NONE)
            begin
                r.reuse[w] = x.reuse[w] - 2'd1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/srrip_db_store.sv
module srrip_db_store (
    input  logic                  clk,
    input  srrip_db_pkg::mem_req_t req,
    output srrip_db_pkg::row_t     rd_row
);

    srrip_db_pkg::row_t mem [srrip_db_pkg::NUM_SETS];
    srrip_db_pkg::row_t rd_row_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_row_reg <= mem[req.raddr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

### rtl/srrip_db_scan.sv
module srrip_db_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic                            step,
    input  logic [1:0]                      lane_val,
    input  logic [srrip_db_pkg::LANE_W-1:0] lane_idx,
    output logic [1:0]                      max_val,
    output logic [srrip_db_pkg::LANE_W-1:0] first_idx
);

    logic [1:0]                      max_reg;
    logic [1:0]                      max_next;
    logic [srrip_db_pkg::LANE_W-1:0] first_reg;
    logic [srrip_db_pkg::LANE_W-1:0] first_next;

    // Running maximum; a strict compare keeps the lowest way that holds it.
    always_comb
    begin
        max_next   = max_reg;
        first_next = first_reg;
        if (clear)
        begin
            max_next   = 2'd0;
            first_next = '0;
        end
        else if (step && (lane_val > max_reg))
        begin
            max_next   = lane_val;
            first_next = lane_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= 2'd0;
            first_reg <= '0;
        end
        else
        begin
            max_reg   <= max_next;
            first_reg <= first_next;
        end
    end

    assign max_val   = max_reg;
    assign first_idx = first_reg;

endmodule

### rtl/srrip_deadblock_replacement.sv
// Channel   Direction  Word contents (lowest bit first)
// s_*       in         tdata: set_index[10:0], way_index[14:11]; tuser: action, hit
// m_*       out        tdata: victim_way[3:0]
// cfg_*     in         cfg_wdata: decay_interval_log2
//
// In a victim query the compare unit looks at one way per cycle.
// An update reads the set's row and then writes it back.
// A fill that triggers a decay then sweeps the store, one row of the store per cycle.
// After reset, a clearing pass writes every row; s_tready stays low.
// A stalled result holds in the output register; the next query waits only in its completion state.
module srrip_deadblock_replacement (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // set_index[10:0], way_index[14:11], zero
    input  logic [1:0]  s_tuser,   // action[0], hit[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // victim_way[3:0], zero
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    localparam int unsigned ADDR_W  = srrip_db_pkg::ADDR_W;
    localparam int unsigned LANE_W  = srrip_db_pkg::LANE_W;
    localparam int unsigned TALLY_W = srrip_db_pkg::TALLY_W;
    localparam int unsigned CFG_W   = srrip_db_pkg::CFG_W;

    srrip_db_pkg::state_t state_reg;
    srrip_db_pkg::state_t state_next;

    logic [CFG_W-1:0]   cfg_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] tally_next;
    logic [ADDR_W-1:0]  sweep_reg;
    logic [ADDR_W-1:0]  sweep_next;
    logic               wr_pend_reg;
    logic               wr_pend_next;
    logic [LANE_W-1:0]  scan_idx_reg;
    logic [LANE_W-1:0]  scan_idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic [ADDR_W-1:0]  wr_addr_next;
    logic [LANE_W-1:0]  lane_reg;
    logic [LANE_W-1:0]  lane_next;
    logic               hit_reg;
    logic               hit_next;
    logic               decay_reg;
    logic               decay_next;
    logic               line_ok_reg;
    logic               line_ok_next;
    logic [3:0]         victim_reg;
    logic [3:0]         victim_next;

    srrip_db_pkg::mem_req_t req;
    srrip_db_pkg::row_t     rd_row;
    srrip_db_pkg::row_t     q_row;
    srrip_db_pkg::row_t     u_row;

    logic               scan_clear;
    logic               scan_step;
    logic [1:0]         scan_max;
    logic [LANE_W-1:0]  scan_first;

    logic [10:0]        in_set;
    logic [3:0]         in_way;
    logic               in_action;
    logic               in_hit;
    logic               set_ok;
    logic               way_ok;
    logic [CFG_W-1:0]   decay_k;
    logic [TALLY_W-1:0] decay_mask;
    logic               tally_zero;
    logic               sweep_last;
    logic               scan_last;

    // Input word fields
    assign in_set    = s_tdata[10:0];
    assign in_way    = s_tdata[14:11];
    assign in_action = s_tuser[0];
    assign in_hit    = s_tuser[1];

    assign set_ok = 32'(in_set) < srrip_db_pkg::NUM_SETS;
    assign way_ok = 32'(in_way) < srrip_db_pkg::NUM_WAYS;

    // Decay check on the incremented tally; intervals above the tally width use every bit.
    assign decay_k    = (cfg_reg > CFG_W'(TALLY_W)) ? CFG_W'(TALLY_W) : cfg_reg;
    assign decay_mask = ~({TALLY_W{1'b1}} << decay_k);
    assign tally_zero = ((tally_reg + TALLY_W'(1)) & decay_mask) == '0;

    assign sweep_last = sweep_reg == ADDR_W'(srrip_db_pkg::NUM_SETS - 1);
    assign scan_last  = scan_idx_reg == LANE_W'(srrip_db_pkg::NUM_WAYS - 1);

    // Aged row: adding 3 - max is adding the complement of max in two bits.
    always_comb
    begin
        q_row = rd_row;
        for (int w = 0; w < srrip_db_pkg::NUM_WAYS; w++)
        begin
            q_row.rrpv[w] = rd_row.rrpv[w] + ~scan_max;
        end
    end

    // Hit or fill of one line
    always_comb
    begin
        u_row = rd_row;
        if (hit_reg)
        begin
            u_row.rrpv[lane_reg] = srrip_db_pkg::RRPV_HIT;
            if (rd_row.reuse[lane_reg] != srrip_db_pkg::REUSE_MAX)
            begin
                u_row.reuse[lane_reg] = rd_row.reuse[lane_reg] + 2'd1;
            end
        end
        else
        begin
            u_row.rrpv[lane_reg] = (rd_row.reuse[lane_reg] == srrip_db_pkg::REUSE_NONE) ?
                                   srrip_db_pkg::RRPV_DISTANT : srrip_db_pkg::RRPV_NEAR;
            u_row.reuse[lane_reg] = srrip_db_pkg::REUSE_INIT;
        end
    end

    // Sequencer: next state and store requests
    always_comb
    begin
        state_next     = state_reg;
        tally_next     = tally_reg;
        sweep_next     = sweep_reg;
        wr_pend_next   = wr_pend_reg;
        scan_idx_next  = scan_idx_reg;
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        wr_addr_next   = wr_addr_reg;
        lane_next      = lane_reg;
        hit_next       = hit_reg;
        decay_next     = decay_reg;
        line_ok_next   = line_ok_reg;
        victim_next    = victim_reg;
        req            = '0;
        scan_clear     = 1'b0;
        scan_step      = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            srrip_db_pkg::ST_CLEAR:
            begin
                req.we     = 1'b1;
                req.waddr  = sweep_reg;
                req.wdata  = srrip_db_pkg::reset_row();
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    state_next = srrip_db_pkg::ST_IDLE;
                end
            end

            srrip_db_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next = ADDR_W'(in_set);
                    lane_next = LANE_W'(in_way);
                    hit_next  = in_hit;
                    req.raddr = ADDR_W'(in_set);
                    if (in_action == srrip_db_pkg::ACT_QUERY)
                    begin
                        scan_clear    = 1'b1;
                        scan_idx_next = '0;
                        line_ok_next  = set_ok;
                        decay_next    = 1'b0;
                        req.re        = set_ok;
                        state_next    = set_ok ? srrip_db_pkg::ST_SCAN : srrip_db_pkg::ST_QDONE;
                    end
                    else
                    begin
                        tally_next   = tally_reg + TALLY_W'(1);
                        decay_next   = !in_hit && tally_zero;
                        line_ok_next = set_ok && way_ok;
                        req.re       = set_ok && way_ok;
                        sweep_next   = '0;
                        wr_pend_next = 1'b0;
                        if (set_ok && way_ok)
                        begin
                            state_next = srrip_db_pkg::ST_UPD;
                        end
                        else if (!in_hit && tally_zero)
                        begin
                            state_next = srrip_db_pkg::ST_DECAY;
                        end
                    end
                end
            end

            srrip_db_pkg::ST_SCAN:
            begin
                scan_step     = 1'b1;
                scan_idx_next = scan_idx_reg + LANE_W'(1);
                if (scan_last)
                begin
                    state_next = srrip_db_pkg::ST_QDONE;
                end
            end

            srrip_db_pkg::ST_QDONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    req.we         = line_ok_reg;
                    req.waddr      = addr_reg;
                    req.wdata      = q_row;
                    out_valid_next = 1'b1;
                    victim_next    = 4'(scan_first);
                    state_next     = srrip_db_pkg::ST_IDLE;
                end
            end

            srrip_db_pkg::ST_UPD:
            begin
                req.we     = 1'b1;
                req.waddr  = addr_reg;
                req.wdata  = u_row;
                state_next = decay_reg ? srrip_db_pkg::ST_DECAY : srrip_db_pkg::ST_IDLE;
            end

            srrip_db_pkg::ST_DECAY:
            begin
                // Read one row ahead while the previous row is written back.
                req.re       = 1'b1;
                req.raddr    = sweep_reg;
                req.we       = wr_pend_reg;
                req.waddr    = wr_addr_reg;
                req.wdata    = srrip_db_pkg::decay_row(rd_row);
                wr_addr_next = sweep_reg;
                wr_pend_next = 1'b1;
                sweep_next   = sweep_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    state_next = srrip_db_pkg::ST_DECAY_LAST;
                end
            end

            srrip_db_pkg::ST_DECAY_LAST:
            begin
                req.we     = 1'b1;
                req.waddr  = wr_addr_reg;
                req.wdata  = srrip_db_pkg::decay_row(rd_row);
                state_next = srrip_db_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = srrip_db_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srrip_db_pkg::ST_CLEAR;
            tally_reg     <= '0;
            sweep_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            sweep_reg     <= sweep_next;
            wr_pend_reg   <= wr_pend_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= srrip_db_pkg::DECAY_LOG2_RST;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        wr_addr_reg <= wr_addr_next;
        lane_reg    <= lane_next;
        hit_reg     <= hit_next;
        decay_reg   <= decay_next;
        line_ok_reg <= line_ok_next;
        victim_reg  <= victim_next;
    end

    srrip_db_store u_store (
        .clk    (clk),
        .req    (req),
        .rd_row (rd_row)
    );

    srrip_db_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .step      (scan_step),
        .lane_val  (rd_row.rrpv[scan_idx_reg]),
        .lane_idx  (scan_idx_reg),
        .max_val   (scan_max),
        .first_idx (scan_first)
    );

    assign s_tready = state_reg == srrip_db_pkg::ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, victim_reg};

    // A new result word comes only from the end of a victim query.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == srrip_db_pkg::ST_QDONE)
        else $error("result raised outside query completion");

    // A fill that hits the decay interval leads to the update write or the sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_action == srrip_db_pkg::ACT_UPDATE && decay_next)
        |=> (state_reg == srrip_db_pkg::ST_UPD || state_reg == srrip_db_pkg::ST_DECAY))
        else $error("decay not started after fill");

    // The store is never read and written at the same row in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.we && req.re && req.waddr == req.raddr))
        else $error("read and write collide on one row");

endmodule
